/* rtl/cfla_pkg.sv */
`default_nettype none

package cfla_pkg;

  localparam int unsigned IdxW   = 10;
  localparam int unsigned CntW   = 11;
  localparam int unsigned BytesW = 25;
  localparam int unsigned OffW   = 35;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_CHUNK  = 2'd1,
    ST_RANGE     = 2'd2,
    ST_NONE_USED = 2'd3
  } status_e;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  localparam logic [CfgIdxW-1:0] REG_CHUNK_TOTAL = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_CHUNK_BYTES = 1'd1;

  // decided result held while a stack read is in flight
  typedef struct packed {
    status_e          status;
    logic             pop;
    logic [IdxW-1:0]  index;
    logic [CntW-1:0]  in_use;
  } res_t;

endpackage

`default_nettype wire

/* rtl/cfla_ram.sv */
`default_nettype none

module cfla_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/cfla_ctrl.sv */
`default_nettype none

module cfla_ctrl #(
  parameter int unsigned MAX_CHUNKS = 1024,
  localparam int unsigned AW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1,
  localparam int unsigned FD_W = $clog2(MAX_CHUNKS + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [cfla_pkg::CntW-1:0]  chunk_total_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       operation_i,
  input  wire logic [cfla_pkg::IdxW-1:0]  chunk_index_i,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output cfla_pkg::res_t                  res_o,
  output logic                            ram_we_o,
  output logic                            ram_re_o,
  output logic [AW-1:0]                   ram_addr_o,
  output logic [cfla_pkg::IdxW-1:0]       ram_wdata_o
);

  logic [FD_W-1:0]           depth_q, depth_d;
  logic [cfla_pkg::CntW-1:0] bump_q, bump_d;
  logic [cfla_pkg::CntW-1:0] used_q, used_d;
  logic                      res_valid_q;
  cfla_pkg::res_t            res_q, res_d;
  logic [cfla_pkg::CntW-1:0] limit;
  logic                      accept;

  // chunk count clamped to the stack size
  always_comb begin
    if (32'(MAX_CHUNKS) < 32'(chunk_total_i)) begin
      limit = cfla_pkg::CntW'(MAX_CHUNKS);
    end else begin
      limit = chunk_total_i;
    end
  end

  assign in_ready_o = !res_valid_q || res_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    depth_d     = depth_q;
    bump_d      = bump_q;
    used_d      = used_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_addr_o  = AW'(depth_q);
    ram_wdata_o = chunk_index_i;
    res_d       = '{status: cfla_pkg::ST_OK, pop: 1'b0, index: '0, in_use: used_q};
    if (accept) begin
      if (operation_i == cfla_pkg::OP_ACQUIRE) begin
        if (depth_q != '0) begin
          depth_d    = depth_q - FD_W'(1);
          used_d     = used_q + cfla_pkg::CntW'(1);
          ram_re_o   = 1'b1;
          ram_addr_o = AW'(depth_q - FD_W'(1));
          res_d.pop  = 1'b1;
        end else if (bump_q < limit) begin
          bump_d      = bump_q + cfla_pkg::CntW'(1);
          used_d      = used_q + cfla_pkg::CntW'(1);
          res_d.index = cfla_pkg::IdxW'(bump_q);
        end else begin
          res_d.status = cfla_pkg::ST_NO_CHUNK;
        end
      end else begin
        if ({1'b0, chunk_index_i} >= limit) begin
          res_d.status = cfla_pkg::ST_RANGE;
        end else if (used_q == '0) begin
          res_d.status = cfla_pkg::ST_NONE_USED;
        end else if (32'(depth_q) >= 32'(MAX_CHUNKS)) begin
          res_d.status = cfla_pkg::ST_NO_CHUNK;
        end else begin
          depth_d     = depth_q + FD_W'(1);
          used_d      = used_q - cfla_pkg::CntW'(1);
          ram_we_o    = 1'b1;
          res_d.index = chunk_index_i;
        end
      end
      res_d.in_use = used_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      bump_q      <= '0;
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      bump_q  <= bump_d;
      used_q  <= used_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* rtl/cfla_out.sv */
`default_nettype none

module cfla_out (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [cfla_pkg::BytesW-1:0] chunk_bytes_i,
  input  wire logic                        res_valid_i,
  output logic                             res_ready_o,
  input  wire cfla_pkg::res_t              res_i,
  input  wire logic [cfla_pkg::IdxW-1:0]   ram_rdata_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [cfla_pkg::IdxW-1:0]        granted_index_o,
  output logic [cfla_pkg::OffW-1:0]        byte_offset_o,
  output logic [1:0]                       status_o,
  output logic [cfla_pkg::CntW-1:0]        in_use_o
);

  logic                        out_valid_q;
  logic [cfla_pkg::IdxW-1:0]   index_q, index_d;
  logic [cfla_pkg::OffW-1:0]   offset_q, offset_d;
  cfla_pkg::status_e           status_q;
  logic [cfla_pkg::CntW-1:0]   in_use_q;
  logic                        load;

  assign res_ready_o = !out_valid_q || out_ready_i;
  assign load        = res_valid_i && res_ready_o;

  // popped index comes straight from the stack read
  assign index_d  = res_i.pop ? ram_rdata_i : res_i.index;
  assign offset_d = cfla_pkg::OffW'(index_d) * cfla_pkg::OffW'(chunk_bytes_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      index_q  <= index_d;
      offset_q <= offset_d;
      status_q <= res_i.status;
      in_use_q <= res_i.in_use;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_index_o = index_q;
  assign byte_offset_o   = offset_q;
  assign status_o        = status_q;
  assign in_use_o        = in_use_q;

endmodule

`default_nettype wire

/* rtl/chunk_free_list_allocator_core.sv */
`default_nettype none

// Fixed-size chunk allocator: acquire pops the most recently released index from a LIFO free
// stack, or else hands out the next never-used index; release pushes an index back. One item
// is taken per clock cycle when the output side keeps up; its result is held in the control
// stage and then in the output register stage, where it is scaled by the chunk size. The rate
// is set by the single-port free-stack RAM, which serves one push or one pop per item; a popped
// index is read in the cycle after acceptance. The free stack needs no clearing after reset.
module chunk_free_list_allocator_core #(
  parameter int unsigned MAX_CHUNKS = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [cfla_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [cfla_pkg::BytesW-1:0]    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           operation_i,
  input  wire logic [cfla_pkg::IdxW-1:0]      chunk_index_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [cfla_pkg::IdxW-1:0]           granted_index_o,
  output logic [cfla_pkg::OffW-1:0]           byte_offset_o,
  output logic [1:0]                          status_o,
  output logic [cfla_pkg::CntW-1:0]           in_use_o
);

  localparam int unsigned AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

  logic [cfla_pkg::CntW-1:0]   chunk_total_q;
  logic [cfla_pkg::BytesW-1:0] chunk_bytes_q;
  logic                        res_valid;
  logic                        res_ready;
  cfla_pkg::res_t              res;
  logic                        ram_we;
  logic                        ram_re;
  logic [AW-1:0]               ram_addr;
  logic [cfla_pkg::IdxW-1:0]   ram_wdata;
  logic [cfla_pkg::IdxW-1:0]   ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_total_q <= cfla_pkg::CntW'(1024);
      chunk_bytes_q <= cfla_pkg::BytesW'(256);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cfla_pkg::REG_CHUNK_TOTAL: chunk_total_q <= cfg_data_i[cfla_pkg::CntW-1:0];
        cfla_pkg::REG_CHUNK_BYTES: chunk_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cfla_ctrl #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chunk_total_i(chunk_total_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .chunk_index_i(chunk_index_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_re_o     (ram_re),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata)
  );

  cfla_ram #(
    .WIDTH(cfla_pkg::IdxW),
    .DEPTH(MAX_CHUNKS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  cfla_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .chunk_bytes_i  (chunk_bytes_q),
    .res_valid_i    (res_valid),
    .res_ready_o    (res_ready),
    .res_i          (res),
    .ram_rdata_i    (ram_rdata),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .granted_index_o(granted_index_o),
    .byte_offset_o  (byte_offset_o),
    .status_o       (status_o),
    .in_use_o       (in_use_o)
  );

endmodule

`default_nettype wire
